### rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the Huffman tree decoder
// Command codes, field widths, controller states and the control and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 8;
  localparam int CODE_W  = 9;
  localparam int ENTRY_W = 2 * CODE_W;
  localparam int LEN_W   = 24;
  localparam int BYTE_W  = 8;
  localparam int BIT_CNT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // write one node entry
    logic start;    // new chunk: length and head node
    logic capture;  // latch a compressed byte
    logic step;     // walk one bit
    logic emit;     // load the output register with the leaf
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;    // chunk still has bytes to decode
    logic bit_last;  // walking the eighth bit of the byte
    logic leaf;      // current bit reaches a leaf
    logic len_one;   // one byte left in the chunk
    logic out_busy;  // output register holds a transaction not taken
  } dp_status_t;

endpackage

### rtl/htd_in_if.sv
// ----------------------------------------------------------------------------
// htd_in_if: input channel of the Huffman tree decoder
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface htd_in_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::CMD_W-1:0]     cmd;
  logic [htd_pkg::NODE_W-1:0]    node_sel;
  logic [htd_pkg::CODE_W-1:0]    zero_code;
  logic [htd_pkg::CODE_W-1:0]    one_code;
  logic [htd_pkg::LEN_W-1:0]     expanded_length;
  logic [htd_pkg::BYTE_W-1:0]    compressed_byte;

  modport source (
    output valid, cmd, node_sel, zero_code, one_code, expanded_length,
           compressed_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, node_sel, zero_code, one_code, expanded_length,
           compressed_byte,
    output ready
  );
endinterface

### rtl/htd_out_if.sv
// ----------------------------------------------------------------------------
// htd_out_if: output channel of the Huffman tree decoder
// Valid/ready channel that carries one decoded byte and its last flag.
// ----------------------------------------------------------------------------
interface htd_out_if;
  logic                        valid;
  logic                        ready;
  logic [htd_pkg::BYTE_W-1:0]  out_byte;
  logic                        last;

  modport source (
    output valid, out_byte, last,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last,
    output ready
  );
endinterface

### rtl/htd_datapath.sv
// ----------------------------------------------------------------------------
// htd_datapath: node table, tree walk and output register
// Holds the node memory with a registered read port, the walk state, the
// byte counter, the bit shifter and the output transaction register.
// ----------------------------------------------------------------------------
module htd_datapath #(
  parameter int NODE_COUNT = 255,
  parameter int HEAD_NODE  = 254
) (
  input  logic                          clk,
  input  logic                          rst,
  input  htd_pkg::ctrl_cmd_t            ctrl,
  output htd_pkg::dp_status_t           status,
  input  logic [htd_pkg::NODE_W-1:0]    node_sel,
  input  logic [htd_pkg::CODE_W-1:0]    zero_code,
  input  logic [htd_pkg::CODE_W-1:0]    one_code,
  input  logic [htd_pkg::LEN_W-1:0]     expanded_length,
  input  logic [htd_pkg::BYTE_W-1:0]    compressed_byte,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [htd_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last
);

  localparam int ADDR_W = $clog2(NODE_COUNT);

  logic [htd_pkg::ENTRY_W-1:0]   node_mem [NODE_COUNT];
  logic [htd_pkg::ENTRY_W-1:0]   rd_entry;
  logic                          rd_oob;

  logic [htd_pkg::NODE_W-1:0]    current_node;
  logic [htd_pkg::NODE_W-1:0]    current_node_next;
  logic [htd_pkg::LEN_W-1:0]     bytes_remaining;
  logic                          active;
  logic [htd_pkg::BYTE_W-1:0]    shift_bits;
  logic [htd_pkg::BIT_CNT_W-1:0] bit_cnt;

  logic [htd_pkg::CODE_W-1:0]    code;
  logic                          leaf;
  logic                          len_one;
  logic                          wr_ok;
  logic                          rd_ok;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;

  // Pick the branch for the current bit; a node beyond the table reads zero.
  always_comb begin
    if (rd_oob) begin
      code = '0;
    end else if (shift_bits[0]) begin
      code = rd_entry[htd_pkg::CODE_W +: htd_pkg::CODE_W];
    end else begin
      code = rd_entry[htd_pkg::CODE_W-1:0];
    end
  end

  assign leaf    = ~code[htd_pkg::CODE_W-1];
  assign len_one = (bytes_remaining == htd_pkg::LEN_W'(1));

  always_comb begin
    current_node_next = current_node;
    if (ctrl.start) begin
      current_node_next = htd_pkg::NODE_W'(HEAD_NODE);
    end else if (ctrl.step) begin
      if (leaf) begin
        current_node_next = htd_pkg::NODE_W'(HEAD_NODE);
      end else begin
        current_node_next = code[htd_pkg::NODE_W-1:0];
      end
    end
  end

  assign wr_ok   = ({1'b0, node_sel} < (htd_pkg::NODE_W+1)'(NODE_COUNT));
  assign rd_ok   = ({1'b0, current_node_next} < (htd_pkg::NODE_W+1)'(NODE_COUNT));
  assign wr_addr = node_sel[ADDR_W-1:0];
  assign rd_addr = rd_ok ? current_node_next[ADDR_W-1:0] : '0;

  // Read the node the walk stands on next, so its entry is ready in the next cycle.
  always_ff @(posedge clk) begin
    if (ctrl.load && wr_ok) begin
      node_mem[wr_addr] <= {one_code, zero_code};
    end
    rd_entry <= node_mem[rd_addr];
    rd_oob   <= ~rd_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_node    <= htd_pkg::NODE_W'(HEAD_NODE);
      bytes_remaining <= '0;
      active          <= 1'b0;
      bit_cnt         <= '0;
    end else begin
      current_node <= current_node_next;
      if (ctrl.start) begin
        bytes_remaining <= expanded_length;
        active          <= (expanded_length != '0);
      end else if (ctrl.step && leaf) begin
        bytes_remaining <= bytes_remaining - htd_pkg::LEN_W'(1);
        if (len_one) begin
          active <= 1'b0;
        end
      end
      if (ctrl.capture) begin
        bit_cnt <= '0;
      end else if (ctrl.step) begin
        bit_cnt <= bit_cnt + htd_pkg::BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      shift_bits <= compressed_byte;
    end else if (ctrl.step) begin
      shift_bits <= {1'b0, shift_bits[htd_pkg::BYTE_W-1:1]};
    end
  end

  // Output transaction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_byte <= code[htd_pkg::BYTE_W-1:0];
      out_last <= len_one;
    end
  end

  assign status.active   = active;
  assign status.bit_last = (bit_cnt == '1);
  assign status.leaf     = leaf;
  assign status.len_one  = len_one;
  assign status.out_busy = out_valid & ~out_ready;

endmodule

### rtl/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl: controller of the Huffman tree decoder
// Takes command items while idle and sequences the bit walk of a data byte.
// ----------------------------------------------------------------------------
module htd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [htd_pkg::CMD_W-1:0]   in_cmd,
  output logic                        in_ready,
  input  htd_pkg::dp_status_t         status,
  output htd_pkg::ctrl_cmd_t          ctrl
);

  htd_pkg::state_t state;
  htd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      htd_pkg::ST_IDLE: begin
        if (in_valid && (in_cmd == htd_pkg::CMD_DATA) && status.active) begin
          state_next = htd_pkg::ST_STEP;
        end
      end
      htd_pkg::ST_STEP: begin
        // leave after the eighth bit or at the leaf that ends the chunk
        if (!status.out_busy &&
            (status.bit_last || (status.leaf && status.len_one))) begin
          state_next = htd_pkg::ST_IDLE;
        end
      end
      default: state_next = htd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      htd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            htd_pkg::CMD_LOAD:  ctrl.load    = 1'b1;
            htd_pkg::CMD_START: ctrl.start   = 1'b1;
            htd_pkg::CMD_DATA:  ctrl.capture = status.active;
            default: ;
          endcase
        end
      end
      htd_pkg::ST_STEP: begin
        // hold the walk while the output register is full
        if (!status.out_busy) begin
          ctrl.step = 1'b1;
          ctrl.emit = status.leaf;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder: Huffman decoder with a loadable node table
// Load and start transactions complete when accepted. A data byte is taken while
// idle and blocks the input during its walk: one tree step per bit, each bound
// by one registered node-table read; it ends early if the chunk ends in the byte,
// and stalls on a full output register. A result is valid after its step.
// Reset (synchronous) puts the walk at the head node, clears count and active.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int NODE_COUNT = 255,
  parameter int HEAD_NODE  = 254
) (
  input logic       clk,
  input logic       rst,
  htd_in_if.sink    in_chan,
  htd_out_if.source out_chan
);

  // Command and status bundles between the sequencer and the walk logic.
  htd_pkg::ctrl_cmd_t  ctrl;
  htd_pkg::dp_status_t status;

  // The controller owns the input handshake: it takes a transaction only
  // while no data byte is being walked. Loads and starts complete at once;
  // a data byte with an active chunk starts the bit walk, otherwise drop it.
  htd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_cmd   (in_chan.cmd),
    .in_ready (in_chan.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // The datapath holds the node memory, the walk position, the remaining
  // byte count and the output register. Its read address follows the next
  // walk position inside the table, so every step has its node entry at hand.
  htd_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .HEAD_NODE  (HEAD_NODE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .status          (status),
    .node_sel        (in_chan.node_sel),
    .zero_code       (in_chan.zero_code),
    .one_code        (in_chan.one_code),
    .expanded_length (in_chan.expanded_length),
    .compressed_byte (in_chan.compressed_byte),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_byte        (out_chan.out_byte),
    .out_last        (out_chan.last)
  );

endmodule
